>>> rtl/sqdo_pkg.sv
`default_nettype none

package sqdo_pkg;

    localparam int BUFFER_BYTES_DEF  = 64 * 1024;
    localparam int MAX_SENTENCE_DEF  = 1024;
    localparam int MAX_SENTENCES_DEF = 1024;
    localparam int READ_BURST_DEF    = 64;

    localparam int REQ_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 11;
    localparam int TIME_W  = 64;
    localparam int MAXB_W  = 7;
    localparam int BUFD_W  = 17;

    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLOSE  = 2'd2;

endpackage

`default_nettype wire

>>> rtl/sentence_queue_drop_oldest.sv
// Channel   Direction  Handshake           Payload
// request   in         in_valid/in_stall   req_type, data_byte, first_byte, sentence_length,
//                                          sentence_time_us, max_bytes
// result    out        out_valid/out_stall out_byte, byte_valid, time_us, last_of_read,
//                                          sentence_finished, buffered_bytes
//
// One request at a time. Append of a byte: ST_APPEND, ST_ACK. Acknowledge-only: ST_ACK.
// First byte: ST_DROP_CHK, plus ST_DROP_UPD per dropped sentence, then ST_APPEND, ST_ACK.
// Read: ST_RD_DESC, then ST_BYTE_RD and ST_BYTE_OUT per byte returned, n <= READ_BURST.
// Results sit in an output register; a stall holds it and pauses the sequencer only
// when the next result is due. Reset is asynchronous; no memory clearing pass.
`default_nettype none

module sentence_queue_drop_oldest #(
    parameter int BUFFER_BYTES  = sqdo_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_SENTENCE  = sqdo_pkg::MAX_SENTENCE_DEF,
    parameter int MAX_SENTENCES = sqdo_pkg::MAX_SENTENCES_DEF,
    parameter int READ_BURST    = sqdo_pkg::READ_BURST_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [sqdo_pkg::REQ_W-1:0]    req_type,
    input  wire logic [sqdo_pkg::BYTE_W-1:0]   data_byte,
    input  wire logic                          first_byte,
    input  wire logic [sqdo_pkg::LEN_W-1:0]    sentence_length,
    input  wire logic [sqdo_pkg::TIME_W-1:0]   sentence_time_us,
    input  wire logic [sqdo_pkg::MAXB_W-1:0]   max_bytes,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [sqdo_pkg::BYTE_W-1:0]        out_byte,
    output logic                               byte_valid,
    output logic [sqdo_pkg::TIME_W-1:0]        time_us,
    output logic                               last_of_read,
    output logic                               sentence_finished,
    output logic [sqdo_pkg::BUFD_W-1:0]        buffered_bytes
);

    localparam int AW   = $clog2(BUFFER_BYTES);
    localparam int DW   = $clog2(MAX_SENTENCES);
    localparam int CW   = $clog2(MAX_SENTENCES + 1);
    localparam int HW   = $clog2(BUFFER_BYTES + 1);
    localparam int LW   = sqdo_pkg::LEN_W;
    localparam int MW   = sqdo_pkg::MAXB_W;
    localparam int TW   = sqdo_pkg::TIME_W;
    localparam int BW   = sqdo_pkg::BYTE_W;

    localparam logic [AW:0]   BUF_SPAN  = (AW+1)'(BUFFER_BYTES);
    localparam logic [AW-1:0] BUF_LAST  = AW'(BUFFER_BYTES - 1);
    localparam logic [DW:0]   DESC_SPAN = (DW+1)'(MAX_SENTENCES);
    localparam logic [DW-1:0] DESC_LAST = DW'(MAX_SENTENCES - 1);
    localparam logic [CW-1:0] DESC_FULL = CW'(MAX_SENTENCES);
    localparam logic [HW:0]   HELD_MAX  = (HW+1)'(BUFFER_BYTES);
    localparam logic [MW-1:0] BURST     = MW'(READ_BURST);

    typedef struct packed {
        logic [AW-1:0] off;
        logic [LW-1:0] rem;
        logic [TW-1:0] ts;
    } desc_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP_CHK,
        ST_DROP_UPD,
        ST_APPEND,
        ST_ACK,
        ST_RD_DESC,
        ST_BYTE_RD,
        ST_BYTE_OUT
    } state_t;

    logic [BW-1:0] byte_mem [BUFFER_BYTES];
    desc_t         desc_mem [MAX_SENTENCES];

    state_t        state_reg;
    logic [DW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] wp_reg;
    logic [HW-1:0] held_reg;
    logic [LW-1:0] btw_reg;
    logic [LW-1:0] cur_total_reg;
    logic [AW-1:0] cur_pos_reg;
    logic [TW-1:0] last_time_reg;
    logic          closed_reg;
    logic [BW-1:0] byte_in_reg;
    logic [LW-1:0] len_reg;
    logic [TW-1:0] ts_reg;
    logic [MW-1:0] maxb_reg;
    logic [AW-1:0] rd_addr_reg;
    logic [MW-1:0] bcnt_reg;
    logic          fin_reg;
    logic [BW-1:0] byte_rd_reg;
    desc_t         desc_rd_reg;
    logic          out_valid_reg;
    logic [BW-1:0] out_byte_reg;
    logic          byte_valid_reg;
    logic [TW-1:0] time_reg;
    logic          last_reg;
    logic          fin_out_reg;
    logic [HW-1:0] held_out_reg;

    logic          accept;
    logic          out_free;
    logic          out_load;
    logic [MW-1:0] maxb_cap;
    logic          len_ok;
    logic          drop_need;
    logic [DW:0]   tail_sum;
    logic [DW-1:0] tail_slot;
    logic [DW-1:0] head_inc;
    logic [AW-1:0] cur_pos_inc;
    logic [AW-1:0] rd_addr_inc;
    logic [MW-1:0] n_rd;
    logic [AW:0]   off_sum;
    logic [AW-1:0] off_new;
    logic          desc_re;
    logic          desc_we;
    logic [DW-1:0] desc_waddr;
    desc_t         desc_wdata;
    logic          byte_re;
    logic          byte_we;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = out_free && ((state_reg == ST_ACK) || (state_reg == ST_BYTE_OUT));
    assign maxb_cap = (max_bytes > BURST) ? BURST : max_bytes;
    assign len_ok   = (sentence_length != '0) && (32'(sentence_length) <= MAX_SENTENCE)
                      && (32'(sentence_length) <= BUFFER_BYTES);

    assign drop_need = (count_reg != '0) &&
                       ((({1'b0, held_reg} + (HW+1)'(len_reg)) > HELD_MAX) ||
                        (count_reg >= DESC_FULL));

    assign tail_sum    = (DW+1)'(head_reg) + (DW+1)'(count_reg);
    assign tail_slot   = (tail_sum >= DESC_SPAN) ? DW'(tail_sum - DESC_SPAN) : DW'(tail_sum);
    assign head_inc    = (head_reg == DESC_LAST) ? '0 : head_reg + 1'b1;
    assign cur_pos_inc = (cur_pos_reg == BUF_LAST) ? '0 : cur_pos_reg + 1'b1;
    assign rd_addr_inc = (rd_addr_reg == BUF_LAST) ? '0 : rd_addr_reg + 1'b1;

    assign n_rd    = (LW'(maxb_reg) < desc_rd_reg.rem) ? maxb_reg : MW'(desc_rd_reg.rem);
    assign off_sum = {1'b0, desc_rd_reg.off} + (AW+1)'(n_rd);
    assign off_new = (off_sum >= BUF_SPAN) ? AW'(off_sum - BUF_SPAN) : AW'(off_sum);

    always_comb
    begin
        desc_re    = (accept && !closed_reg && (req_type == sqdo_pkg::REQ_READ) &&
                      (count_reg != '0) && (maxb_cap != '0)) ||
                     ((state_reg == ST_DROP_CHK) && drop_need);
        desc_we    = 1'b0;
        desc_waddr = tail_slot;
        desc_wdata = '{off: wp_reg, rem: len_reg, ts: ts_reg};
        if ((state_reg == ST_DROP_CHK) && !drop_need)
        begin
            desc_we = 1'b1;
        end
        else if (state_reg == ST_RD_DESC)
        begin
            desc_we    = 1'b1;
            desc_waddr = head_reg;
            desc_wdata = '{off: off_new, rem: desc_rd_reg.rem - LW'(n_rd),
                           ts: desc_rd_reg.ts};
        end
        byte_we = (state_reg == ST_APPEND) && (btw_reg != '0);
        byte_re = (state_reg == ST_BYTE_RD);
    end

    always_ff @(posedge clk)
    begin
        if (desc_we)
        begin
            desc_mem[desc_waddr] <= desc_wdata;
        end
        if (desc_re)
        begin
            desc_rd_reg <= desc_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            byte_mem[cur_pos_reg] <= byte_in_reg;
        end
        if (byte_re)
        begin
            byte_rd_reg <= byte_mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            wp_reg        <= '0;
            held_reg      <= '0;
            btw_reg       <= '0;
            last_time_reg <= '0;
            closed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_load || (out_valid_reg && out_stall);
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        byte_in_reg <= data_byte;
                        len_reg     <= sentence_length;
                        ts_reg      <= sentence_time_us;
                        maxb_reg    <= maxb_cap;
                        if (closed_reg)
                        begin
                            state_reg <= ST_ACK;
                        end
                        else
                        begin
                            case (req_type)
                                sqdo_pkg::REQ_APPEND:
                                begin
                                    if (first_byte)
                                    begin
                                        btw_reg   <= '0;
                                        state_reg <= len_ok ? ST_DROP_CHK : ST_ACK;
                                    end
                                    else
                                    begin
                                        state_reg <= ST_APPEND;
                                    end
                                end
                                sqdo_pkg::REQ_READ:
                                begin
                                    state_reg <= ((count_reg != '0) && (maxb_cap != '0)) ?
                                                 ST_RD_DESC : ST_ACK;
                                end
                                sqdo_pkg::REQ_CLOSE:
                                begin
                                    count_reg  <= '0;
                                    held_reg   <= '0;
                                    btw_reg    <= '0;
                                    closed_reg <= 1'b1;
                                    state_reg  <= ST_ACK;
                                end
                                default:
                                begin
                                    state_reg <= ST_ACK;
                                end
                            endcase
                        end
                    end
                end
                ST_DROP_CHK:
                begin
                    if (drop_need)
                    begin
                        state_reg <= ST_DROP_UPD;
                    end
                    else
                    begin
                        btw_reg       <= len_reg;
                        cur_total_reg <= len_reg;
                        cur_pos_reg   <= wp_reg;
                        state_reg     <= ST_APPEND;
                    end
                end
                ST_DROP_UPD:
                begin
                    held_reg  <= held_reg - HW'(desc_rd_reg.rem);
                    head_reg  <= head_inc;
                    count_reg <= count_reg - 1'b1;
                    state_reg <= ST_DROP_CHK;
                end
                ST_APPEND:
                begin
                    if (btw_reg != '0)
                    begin
                        btw_reg     <= btw_reg - 1'b1;
                        cur_pos_reg <= cur_pos_inc;
                        if (btw_reg == LW'(1))
                        begin
                            count_reg <= count_reg + 1'b1;
                            held_reg  <= held_reg + HW'(cur_total_reg);
                            wp_reg    <= cur_pos_inc;
                        end
                    end
                    state_reg <= ST_ACK;
                end
                ST_ACK:
                begin
                    if (out_free)
                    begin
                        out_byte_reg   <= '0;
                        byte_valid_reg <= 1'b0;
                        time_reg       <= last_time_reg;
                        last_reg       <= 1'b1;
                        fin_out_reg    <= 1'b0;
                        held_out_reg   <= held_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                ST_RD_DESC:
                begin
                    last_time_reg <= desc_rd_reg.ts;
                    held_reg      <= held_reg - HW'(n_rd);
                    rd_addr_reg   <= desc_rd_reg.off;
                    bcnt_reg      <= n_rd;
                    fin_reg       <= (desc_rd_reg.rem == LW'(n_rd));
                    if (desc_rd_reg.rem == LW'(n_rd))
                    begin
                        head_reg  <= head_inc;
                        count_reg <= count_reg - 1'b1;
                    end
                    state_reg <= ST_BYTE_RD;
                end
                ST_BYTE_RD:
                begin
                    state_reg <= ST_BYTE_OUT;
                end
                ST_BYTE_OUT:
                begin
                    if (out_free)
                    begin
                        out_byte_reg   <= byte_rd_reg;
                        byte_valid_reg <= 1'b1;
                        time_reg       <= last_time_reg;
                        last_reg       <= (bcnt_reg == MW'(1));
                        fin_out_reg    <= (bcnt_reg == MW'(1)) && fin_reg;
                        held_out_reg   <= held_reg;
                        bcnt_reg       <= bcnt_reg - 1'b1;
                        rd_addr_reg    <= rd_addr_inc;
                        state_reg      <= (bcnt_reg == MW'(1)) ? ST_IDLE : ST_BYTE_RD;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_byte          = out_byte_reg;
    assign byte_valid        = byte_valid_reg;
    assign time_us           = time_reg;
    assign last_of_read      = last_reg;
    assign sentence_finished = fin_out_reg;
    assign buffered_bytes    = sqdo_pkg::BUFD_W'(held_out_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DESC_FULL)
        else $error("descriptor count above queue depth");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HW'(BUFFER_BYTES))
        else $error("held bytes above buffer size");

    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |-> (count_reg == '0) && (held_reg == '0) && (btw_reg == '0))
        else $error("queue not empty after close");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("request accepted without processing");

    a_ack_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !byte_valid_reg) |-> (last_reg && !fin_out_reg &&
                                                (out_byte_reg == '0)))
        else $error("malformed acknowledge result");

endmodule

`default_nettype wire

>>> verif/sqdo_checker.sv
`timescale 1ns / 100ps

module sqdo_checker
    import sqdo_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_stall,
    input  wire logic [REQ_W-1:0]    req_type,
    input  wire logic [BYTE_W-1:0]   data_byte,
    input  wire logic                first_byte,
    input  wire logic [LEN_W-1:0]    sentence_length,
    input  wire logic [TIME_W-1:0]   sentence_time_us,
    input  wire logic [MAXB_W-1:0]   max_bytes,
    input  wire logic                out_valid,
    input  wire logic                out_stall,
    input  wire logic [BYTE_W-1:0]   out_byte,
    input  wire logic                byte_valid,
    input  wire logic [TIME_W-1:0]   time_us,
    input  wire logic                last_of_read,
    input  wire logic                sentence_finished,
    input  wire logic [BUFD_W-1:0]   buffered_bytes,
    output int                       mismatches,
    output int                       outstanding,
    output int                       beats_checked,
    output int                       sentences_dropped
);

    localparam int OWED_DEPTH = 256;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              valid;
        logic [TIME_W-1:0] stamp;
        logic              last;
        logic              finished;
        logic [BUFD_W-1:0] held;
    } beat_t;

    logic [BYTE_W-1:0] ring_mem    [BUFFER_BYTES_DEF];
    logic [15:0]       slot_offset [MAX_SENTENCES_DEF];
    logic [LEN_W-1:0]  slot_left   [MAX_SENTENCES_DEF];
    logic [TIME_W-1:0] slot_stamp  [MAX_SENTENCES_DEF];

    logic [9:0]        head;
    logic [10:0]       count;
    logic [15:0]       wr_ptr;
    logic [BUFD_W-1:0] held;
    logic [LEN_W-1:0]  to_write;
    logic [TIME_W-1:0] last_stamp;
    logic              closed;

    beat_t             owed_mem [OWED_DEPTH];
    logic [7:0]        owed_rd;
    logic [7:0]        owed_wr;
    int                owed_count;

    task automatic owe(input logic [BYTE_W-1:0] d, input logic v, input logic l,
                       input logic f);
        beat_t b;
        b.data     = d;
        b.valid    = v;
        b.stamp    = last_stamp;
        b.last     = l;
        b.finished = f;
        b.held     = held;
        if (owed_count == OWED_DEPTH)
        begin
            $error("expected result store overflow");
            mismatches++;
        end
        else
        begin
            owed_mem[owed_wr] = b;
            owed_wr = owed_wr + 1'b1;
            owed_count++;
        end
    endtask

    task automatic take_byte(input logic [BYTE_W-1:0] d, input logic first,
                             input logic [LEN_W-1:0] len, input logic [TIME_W-1:0] ts);
        logic [9:0]       slot;
        logic [LEN_W-1:0] total;
        logic [15:0]      pos;
        if (first)
        begin
            to_write = '0;
            if (len == 0 || len > MAX_SENTENCE_DEF || len > BUFFER_BYTES_DEF)
                return;
            // make room: drop whole sentences from the front
            while (count > 0 && (held + len > BUFFER_BYTES_DEF || count >= MAX_SENTENCES_DEF))
            begin
                held = held - BUFD_W'(slot_left[head]);
                head = head + 1'b1;
                count = count - 1'b1;
                sentences_dropped++;
            end
            slot = 10'(head + count);
            slot_offset[slot] = wr_ptr;
            slot_left[slot]   = len;
            slot_stamp[slot]  = ts;
            to_write = len;
        end
        else if (to_write == 0)
            return;
        slot  = 10'(head + count);
        total = slot_left[slot];
        pos   = slot_offset[slot] + 16'(total - to_write);
        ring_mem[pos] = d;
        to_write = to_write - 1'b1;
        if (to_write == 0)
        begin
            count  = count + 1'b1;
            held   = held + BUFD_W'(total);
            wr_ptr = wr_ptr + 16'(total);
        end
    endtask

    task automatic process_request(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] d,
                                   input logic first, input logic [LEN_W-1:0] len,
                                   input logic [TIME_W-1:0] ts, input logic [MAXB_W-1:0] maxb);
        int               cap;
        int               n;
        logic [15:0]      off;
        logic [15:0]      pos;
        logic [LEN_W-1:0] rem;
        logic             done;
        if (closed)
        begin
            owe('0, 1'b0, 1'b1, 1'b0);
            return;
        end
        case (req)
            REQ_APPEND:
            begin
                take_byte(d, first, len, ts);
                owe('0, 1'b0, 1'b1, 1'b0);
            end
            REQ_CLOSE:
            begin
                count    = '0;
                held     = '0;
                to_write = '0;
                closed   = 1'b1;
                owe('0, 1'b0, 1'b1, 1'b0);
            end
            REQ_READ:
            begin
                cap = (maxb > READ_BURST_DEF) ? READ_BURST_DEF : int'(maxb);
                if (count == 0 || cap == 0)
                    owe('0, 1'b0, 1'b1, 1'b0);
                else
                begin
                    off  = slot_offset[head];
                    rem  = slot_left[head];
                    n    = (cap < int'(rem)) ? cap : int'(rem);
                    last_stamp = slot_stamp[head];
                    slot_offset[head] = off + 16'(n);
                    slot_left[head]   = rem - LEN_W'(n);
                    held = held - BUFD_W'(n);
                    done = (int'(rem) == n);
                    if (done)
                    begin
                        head  = head + 1'b1;
                        count = count - 1'b1;
                    end
                    for (int i = 0; i < n; i++)
                    begin
                        pos = off + 16'(i);
                        owe(ring_mem[pos], 1'b1, i == n - 1, (i == n - 1) && done);
                    end
                end
            end
            default: owe('0, 1'b0, 1'b1, 1'b0);
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        beat_t exp;
        if (!rst_n)
        begin
            head = '0;
            count = '0;
            wr_ptr = '0;
            held = '0;
            to_write = '0;
            last_stamp = '0;
            closed = 1'b0;
            owed_rd = '0;
            owed_wr = '0;
            owed_count = 0;
            mismatches = 0;
            outstanding = 0;
            beats_checked = 0;
            sentences_dropped = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                process_request(req_type, data_byte, first_byte, sentence_length,
                                sentence_time_us, max_bytes);
            if (out_valid && !out_stall)
            begin
                if (owed_count == 0)
                begin
                    $error("result with nothing expected: out_byte %0h byte_valid %0b",
                           out_byte, byte_valid);
                    mismatches++;
                end
                else
                begin
                    exp = owed_mem[owed_rd];
                    owed_rd = owed_rd + 1'b1;
                    owed_count--;
                    check_field("out_byte", 64'(exp.data), 64'(out_byte));
                    check_field("byte_valid", 64'(exp.valid), 64'(byte_valid));
                    check_field("time_us", exp.stamp, time_us);
                    check_field("last_of_read", 64'(exp.last), 64'(last_of_read));
                    check_field("sentence_finished", 64'(exp.finished),
                                64'(sentence_finished));
                    check_field("buffered_bytes", 64'(exp.held), 64'(buffered_bytes));
                    beats_checked++;
                end
            end
            outstanding = owed_count;
        end
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import sqdo_pkg::*;

    localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_END = 175;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [REQ_W-1:0]    req_type = REQ_APPEND;
    logic [BYTE_W-1:0]   data_byte = '0;
    logic                first_byte = 1'b0;
    logic [LEN_W-1:0]    sentence_length = '0;
    logic [TIME_W-1:0]   sentence_time_us = '0;
    logic [MAXB_W-1:0]   max_bytes = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [BYTE_W-1:0]   out_byte;
    logic                byte_valid;
    logic [TIME_W-1:0]   time_us;
    logic                last_of_read;
    logic                sentence_finished;
    logic [BUFD_W-1:0]   buffered_bytes;

    int mismatches;
    int outstanding;
    int beats_checked;
    int sentences_dropped;

    int burst_left = 0;
    int requests_sent = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    int stall_mode = 0;

    sentence_queue_drop_oldest u_top (.*);

    sqdo_checker u_checker (.*);

    always #5 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] d,
                        input logic first, input logic [LEN_W-1:0] len,
                        input logic [TIME_W-1:0] ts, input logic [MAXB_W-1:0] maxb);
        int gap;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 16);
        end
        in_valid         <= 1'b1;
        req_type         <= req;
        data_byte        <= d;
        first_byte       <= first;
        sentence_length  <= len;
        sentence_time_us <= ts;
        max_bytes        <= maxb;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        requests_sent++;
    endtask

    // first byte carries length and stamp; only sent_bytes of it go out
    task automatic append_sentence(input int len, input int sent_bytes);
        send(REQ_APPEND, BYTE_W'($urandom), 1'b1, LEN_W'(len), rand64(),
             MAXB_W'($urandom));
        for (int i = 1; i < sent_bytes; i++)
            send(REQ_APPEND, BYTE_W'($urandom), 1'b0, LEN_W'($urandom), rand64(),
                 MAXB_W'($urandom));
    endtask

    task automatic read_request(input int maxb);
        send(REQ_READ, BYTE_W'($urandom), 1'($urandom), LEN_W'($urandom), rand64(),
             MAXB_W'(maxb));
    endtask

    task automatic junk_request(input logic [REQ_W-1:0] req);
        send(req, BYTE_W'($urandom), 1'($urandom), LEN_W'($urandom), rand64(),
             MAXB_W'($urandom));
    endtask

    // receiver stall, mode changes every so often
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 200);
        end
        stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= (stall_left % 4 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no request or result moved for %0d cycles", idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        int r;
        int len;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed corners
        read_request(64);
        send(REQ_APPEND, 8'h5A, 1'b0, 11'd3, rand64(), '0);
        send(REQ_APPEND, 8'h01, 1'b1, 11'd0, rand64(), '0);
        send(REQ_APPEND, 8'h02, 1'b0, 11'd0, rand64(), '0);
        send(REQ_APPEND, 8'h03, 1'b1, 11'd1025, rand64(), '0);
        send(REQ_APPEND, 8'h04, 1'b0, 11'd1025, rand64(), '0);
        send(REQ_APPEND, 8'h05, 1'b1, 11'h7FF, rand64(), '0);
        send(REQ_RESERVED, 8'hFF, 1'b1, 11'd1, rand64(), 7'h7F);
        send(REQ_APPEND, 8'hFF, 1'b1, 11'd3, '1, '0);
        send(REQ_APPEND, 8'h00, 1'b0, 11'd0, '0, '0);
        read_request(64);
        send(REQ_APPEND, 8'hA5, 1'b0, 11'h7FF, '1, '1);
        read_request(0);
        read_request(2);
        read_request(127);
        send(REQ_APPEND, 8'h11, 1'b1, 11'd2, '0, '0);
        append_sentence(1, 1);
        read_request(64);

        // random traffic, mostly well-formed
        while (requests_sent < RANDOM_END)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                len = $urandom_range(1, 12);
                append_sentence(len, len);
            end
            else if (r < 85)
                read_request($urandom_range(0, 127));
            else if (r < 90)
            begin
                len = $urandom_range(2, 12);
                append_sentence(len, $urandom_range(1, len - 1));
            end
            else if (r < 94)
                send(REQ_APPEND, BYTE_W'($urandom), 1'b0, LEN_W'($urandom), rand64(),
                     MAXB_W'($urandom));
            else if (r < 97)
            begin
                send(REQ_APPEND, BYTE_W'($urandom), 1'b1,
                     ($urandom_range(0, 1) == 0) ? 11'd0 : 11'($urandom_range(1025, 2047)),
                     rand64(), MAXB_W'($urandom));
                send(REQ_APPEND, BYTE_W'($urandom), 1'b0, LEN_W'($urandom), rand64(),
                     MAXB_W'($urandom));
            end
            else
                junk_request(REQ_RESERVED);
        end

        // close, then requests that must all be ignored
        junk_request(REQ_CLOSE);
        read_request(64);
        append_sentence(1, 1);
        junk_request(REQ_CLOSE);
        junk_request(REQ_RESERVED);
        in_valid <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);

        $display("Sent %0d requests and checked %0d results; %0d sentences dropped as oldest.",
                 requests_sent, beats_checked, sentences_dropped);
        $display("Covered: malformed and abandoned sentences, capped and empty reads, close.");
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
rtl/sqdo_pkg.sv
rtl/sentence_queue_drop_oldest.sv
verif/sqdo_checker.sv
verif/tb.sv
